[rtl/mps_pkg.sv]
// Package with shared types and constants of the motion point sequencer.
package mps_pkg;

    localparam int PointDepthDefault = 1024;
    localparam int EventDepthDefault = 64;
    localparam logic [15:0] HoldoffReset = 16'd25;

    typedef enum logic [1:0] {
        REQ_POINT  = 2'd0,
        REQ_EVENT  = 2'd1,
        REQ_STATUS = 2'd2,
        REQ_TICK   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_POINT  = 2'd0,
        KIND_EVENT  = 2'd1,
        KIND_RESYNC = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [31:0]        seq;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] rot_a;
        logic signed [31:0] rot_b;
        logic signed [31:0] rot_c;
        logic [7:0]         tool_id;
        logic signed [31:0] extrude;
        logic [7:0]         ev_code;
        logic               ready_req;
    } t_in;

    typedef struct packed {
        logic [1:0]         out_kind;
        logic [31:0]        out_seq;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_a;
        logic signed [31:0] out_b;
        logic signed [31:0] out_c;
        logic [7:0]         out_tool;
        logic signed [31:0] out_extrude;
        logic [7:0]         out_ev_code;
        logic               last_of_run;
    } t_out;

    // Point store word: seq, tool and the seven coordinates.
    typedef struct packed {
        logic [31:0] seq;
        logic [7:0]  tool;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] e;
    } t_point;

endpackage

[rtl/mps_if.sv]
// Valid/ready channel interfaces for requests and results.
interface mps_in_if;
    logic         valid;
    logic         ready;
    mps_pkg::t_in payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface mps_out_if;
    logic          valid;
    logic          ready;
    mps_pkg::t_out payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/motion_point_sequencer_with_event_hold.sv]
// Top level of the motion point sequencer with event hold.
//   channel  dir  handshake     payload
//   i_req    in   valid/ready   mps_pkg::t_in
//   o_res    out  valid/ready   mps_pkg::t_out
//   cfg      in   i_cfg_we      i_cfg_wdata, resync holdoff ticks
// A push or status request passes S_IDLE and S_TICK. A tick also passes S_PREAD
// and S_PCHK per point read from the point memory (registered read), then the
// emit states, one per result, as results leave through one output register.
// Reset is synchronous; the stores hold no reset value and need no sweep.
// A stalled output holds the block in its emit state; no request is taken.
module motion_point_sequencer_with_event_hold #(
    parameter int POINT_DEPTH = mps_pkg::PointDepthDefault,
    parameter int EVENT_DEPTH = mps_pkg::EventDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mps_in_if.sink      i_req,
    mps_out_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    localparam int PW = $clog2(POINT_DEPTH);
    localparam int EW = $clog2(EVENT_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_TICK, S_PREAD, S_PCHK, S_EMIT1, S_EMIT2
    } t_state;

    t_state r_state;
    mps_pkg::t_in r_in;
    mps_pkg::t_point mem_p [POINT_DEPTH];
    logic [39:0] mem_e [EVENT_DEPTH];
    mps_pkg::t_point r_prd;
    logic [39:0] r_erd;

    logic [PW-1:0] r_phead;
    logic [PW:0]   r_pcount;
    logic [EW-1:0] r_ehead;
    logic [EW:0]   r_ecount;
    logic          r_wait, r_rflag;
    logic [31:0]   r_nexp;
    mps_pkg::t_point r_held;
    logic          r_pend_v;
    logic [39:0]   r_pend;
    logic          r_rdy_v;
    logic [39:0]   r_rdy;
    logic [15:0]   r_age, r_holdoff;
    mps_pkg::t_out r_first_item;
    logic          r_ovalid;
    mps_pkg::t_out r_out;

    logic [PW-1:0] ptail;
    logic [EW-1:0] etail;
    logic          pfull, efull;
    mps_pkg::t_out held_item;
    mps_pkg::t_out ev_item;
    mps_pkg::t_out rs_item;
    logic          emit_load;

    // Tail index (head plus count, wrapped at the depth), full flags and output items.
    always_comb begin
        logic [PW:0] ps;
        logic [EW:0] es;
        ps = {1'b0, r_phead} + r_pcount;
        es = {1'b0, r_ehead} + r_ecount;
        if (ps >= (PW+1)'(POINT_DEPTH)) ps = ps - (PW+1)'(POINT_DEPTH);
        if (es >= (EW+1)'(EVENT_DEPTH)) es = es - (EW+1)'(EVENT_DEPTH);
        ptail = ps[PW-1:0];
        etail = es[EW-1:0];
        pfull = (r_pcount == (PW+1)'(POINT_DEPTH));
        efull = (r_ecount == (EW+1)'(EVENT_DEPTH));
        held_item = '0;
        held_item.out_kind = mps_pkg::KIND_POINT;
        held_item.out_seq = r_held.seq;
        held_item.out_x = r_held.x;
        held_item.out_y = r_held.y;
        held_item.out_z = r_held.z;
        held_item.out_a = r_held.a;
        held_item.out_b = r_held.b;
        held_item.out_c = r_held.c;
        held_item.out_tool = r_held.tool;
        held_item.out_extrude = r_held.e;
        held_item.last_of_run = 1'b1;
        ev_item = '0;
        ev_item.out_kind = mps_pkg::KIND_EVENT;
        ev_item.out_seq = r_erd[31:0];
        ev_item.out_ev_code = r_erd[39:32];
        rs_item = '0;
        rs_item.out_kind = mps_pkg::KIND_RESYNC;
        rs_item.out_seq = r_nexp;
    end

    function automatic logic [PW-1:0] pinc(input logic [PW-1:0] v);
        return (v == PW'(POINT_DEPTH - 1)) ? '0 : v + 1'b1;
    endfunction

    assign i_req.ready = (r_state == S_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.payload = r_out;
    assign emit_load = (r_state == S_EMIT1 || r_state == S_EMIT2) &&
                       (!r_ovalid || o_res.ready);

    // Memories: write on push, registered read at the head.
    always_ff @(posedge i_clk) begin
        if (r_state == S_TICK && r_in.req_type == mps_pkg::REQ_POINT && !pfull)
            mem_p[ptail] <= '{seq: r_in.seq, tool: r_in.tool_id, x: r_in.pos_x,
                              y: r_in.pos_y, z: r_in.pos_z, a: r_in.rot_a,
                              b: r_in.rot_b, c: r_in.rot_c, e: r_in.extrude};
        if (r_state == S_TICK && r_in.req_type == mps_pkg::REQ_EVENT && !efull)
            mem_e[etail] <= {r_in.ev_code, r_in.seq};
        r_prd <= mem_p[r_phead];
        r_erd <= mem_e[r_ehead];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phead <= '0; r_pcount <= '0; r_ehead <= '0; r_ecount <= '0;
            r_wait <= 1'b1; r_rflag <= 1'b0; r_nexp <= '0; r_held <= '0;
            r_pend_v <= 1'b0; r_pend <= '0; r_rdy_v <= 1'b0; r_rdy <= '0;
            r_age <= '0; r_holdoff <= mps_pkg::HoldoffReset;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_holdoff <= i_cfg_wdata;
            if (emit_load) r_ovalid <= 1'b1;
            else if (o_res.valid && o_res.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_in <= i_req.payload;
                        r_state <= S_TICK;
                    end
                end
                S_TICK: begin
                    unique case (mps_pkg::t_req'(r_in.req_type))
                        mps_pkg::REQ_POINT: begin
                            if (!pfull) r_pcount <= r_pcount + 1'b1;
                            r_state <= S_IDLE;
                        end
                        mps_pkg::REQ_EVENT: begin
                            if (!efull) r_ecount <= r_ecount + 1'b1;
                            r_state <= S_IDLE;
                        end
                        mps_pkg::REQ_STATUS: begin
                            r_rdy_v <= r_in.ready_req;
                            r_rdy <= {r_in.ev_code, r_in.seq};
                            r_state <= S_IDLE;
                        end
                        mps_pkg::REQ_TICK: begin
                            // r_erd holds the event head (registered read).
                            if (r_age != 16'hFFFF) r_age <= r_age + 1'b1;
                            if (r_wait) begin
                                if (r_rdy_v && (!r_pend_v || r_pend == r_rdy)) begin
                                    r_wait <= 1'b0;
                                    r_pend_v <= 1'b0;
                                    r_pend <= '0;
                                end
                                r_state <= S_EMIT2;
                            end else if (r_ecount != '0 && r_erd[31:0] <= r_nexp) begin
                                r_ehead <= (r_ehead == EW'(EVENT_DEPTH - 1))
                                           ? '0 : r_ehead + 1'b1;
                                r_ecount <= r_ecount - 1'b1;
                                r_pend_v <= 1'b1;
                                r_pend <= r_erd;
                                r_wait <= 1'b1;
                                r_first_item <= ev_item;
                                r_state <= S_EMIT1;
                            end else if (r_pcount != '0) begin
                                r_state <= S_PREAD;
                            end else begin
                                r_state <= S_EMIT2;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_PREAD: r_state <= S_PCHK;  // memory read of the new head
                S_PCHK: begin
                    r_phead <= pinc(r_phead);
                    if (r_prd.seq < r_nexp) begin
                        r_pcount <= r_pcount - 1'b1;
                        r_state <= (r_pcount != (PW+1)'(1)) ? S_PREAD : S_EMIT2;
                    end else if (r_prd.seq == r_nexp) begin
                        r_pcount <= r_pcount - 1'b1;
                        r_held <= r_prd;
                        r_nexp <= r_nexp + 1'b1;
                        r_rflag <= 1'b0;
                        r_state <= S_EMIT2;
                    end else begin
                        r_pcount <= '0;
                        if (!r_rflag || r_age > r_holdoff) begin
                            r_rflag <= 1'b1;
                            r_age <= '0;
                            r_first_item <= rs_item;
                            r_state <= S_EMIT1;
                        end else begin
                            r_state <= S_EMIT2;
                        end
                    end
                end
                S_EMIT1: begin
                    if (emit_load) begin
                        r_out <= r_first_item;
                        r_state <= S_EMIT2;
                    end
                end
                S_EMIT2: begin
                    if (emit_load) begin
                        r_out <= held_item;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcount <= (PW+1)'(POINT_DEPTH) && r_ecount <= (EW+1)'(EVENT_DEPTH))
        else $error("queue count beyond depth");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT2 && r_ovalid && !o_res.ready) |=> r_state == S_EMIT2)
        else $error("held point lost under stall");
    a_event_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT1 && r_first_item.out_kind == mps_pkg::KIND_EVENT)
        |-> r_wait && r_pend_v)
        else $error("event sent without entering wait");
endmodule

[tb/tb_if_note.sv]
// Testbench-side helper types for the motion point sequencer bench.
package mps_tb_pkg;
    import mps_pkg::*;

    // Scoreboard: predicts the expected result items and checks results against them.
    class seq_scoreboard;
        // Predictor state.
        bit          waiting;
        logic [31:0] exp_seq;
        t_out        held;
        t_point      points[$];
        logic [39:0] events[$];
        logic        pend_valid;
        logic [39:0] pend;
        logic        rdy;
        logic [39:0] rdy_word;
        bit          resync_sent;
        logic [15:0] age;
        logic [15:0] holdoff;
        int          point_cap;
        int          event_cap;
        t_out        expected[$];
        int          errors;

        function new(int pcap, int ecap);
            point_cap = pcap;
            event_cap = ecap;
            waiting = 1;
            exp_seq = '0;
            held = '0;
            held.last_of_run = 1'b1;
            pend_valid = 0;
            pend = '0;
            rdy = 0;
            rdy_word = '0;
            resync_sent = 0;
            age = '0;
            holdoff = HoldoffReset;
            errors = 0;
        endfunction

        // Notes an accepted request and predicts the results it causes.
        function void note_request(t_in r);
            t_point p;
            t_out o;
            logic [39:0] ev;
            case (t_req'(r.req_type))
                REQ_POINT: begin
                    if (points.size() < point_cap) begin
                        p = '{seq: r.seq, tool: r.tool_id, x: r.pos_x, y: r.pos_y,
                              z: r.pos_z, a: r.rot_a, b: r.rot_b, c: r.rot_c,
                              e: r.extrude};
                        points.insert(points.size(), p);
                    end
                end
                REQ_EVENT: begin
                    if (events.size() < event_cap) begin
                        ev = {r.ev_code, r.seq};
                        events.insert(events.size(), ev);
                    end
                end
                REQ_STATUS: begin
                    rdy = r.ready_req;
                    rdy_word = {r.ev_code, r.seq};
                end
                default: begin
                    if (age != 16'hFFFF) age++;
                    if (waiting) begin
                        if (rdy && (!pend_valid || pend == rdy_word)) begin
                            waiting = 0;
                            pend_valid = 0;
                            pend = '0;
                        end
                    end else if (events.size() != 0 && events[0][31:0] <= exp_seq) begin
                        ev = events[0];
                        events.delete(0);
                        pend = ev;
                        pend_valid = 1;
                        waiting = 1;
                        o = '0;
                        o.out_kind = KIND_EVENT;
                        o.out_seq = ev[31:0];
                        o.out_ev_code = ev[39:32];
                        expected.insert(expected.size(), o);
                    end else begin
                        while (points.size() != 0) begin
                            p = points[0];
                            points.delete(0);
                            if (p.seq < exp_seq) continue;
                            if (p.seq == exp_seq) begin
                                held.out_seq = p.seq;
                                held.out_x = p.x;
                                held.out_y = p.y;
                                held.out_z = p.z;
                                held.out_a = p.a;
                                held.out_b = p.b;
                                held.out_c = p.c;
                                held.out_tool = p.tool;
                                held.out_extrude = p.e;
                                exp_seq++;
                                resync_sent = 0;
                            end else begin
                                points.delete();
                                if (!resync_sent || age > holdoff) begin
                                    o = '0;
                                    o.out_kind = KIND_RESYNC;
                                    o.out_seq = exp_seq;
                                    expected.insert(expected.size(), o);
                                    resync_sent = 1;
                                    age = '0;
                                end
                            end
                            break;
                        end
                    end
                    expected.insert(expected.size(), held);
                end
            endcase
        endfunction

        // Compares one accepted result with the oldest expectation.
        function void check_result(t_out a);
            t_out e;
            if (expected.size() == 0) begin
                $error("unexpected result kind=%0d seq=%0d", a.out_kind, a.out_seq);
                errors++;
                return;
            end
            e = expected[0];
            expected.delete(0);
            if (a !== e) begin
                errors++;
                if (a.out_kind !== e.out_kind)
                    $error("out_kind exp %0d got %0d", e.out_kind, a.out_kind);
                if (a.out_seq !== e.out_seq)
                    $error("out_seq exp %0d got %0d", e.out_seq, a.out_seq);
                if (a.out_x !== e.out_x) $error("out_x exp %0d got %0d", e.out_x, a.out_x);
                if (a.out_y !== e.out_y) $error("out_y exp %0d got %0d", e.out_y, a.out_y);
                if (a.out_z !== e.out_z) $error("out_z exp %0d got %0d", e.out_z, a.out_z);
                if (a.out_a !== e.out_a) $error("out_a exp %0d got %0d", e.out_a, a.out_a);
                if (a.out_b !== e.out_b) $error("out_b exp %0d got %0d", e.out_b, a.out_b);
                if (a.out_c !== e.out_c) $error("out_c exp %0d got %0d", e.out_c, a.out_c);
                if (a.out_tool !== e.out_tool)
                    $error("out_tool exp %0d got %0d", e.out_tool, a.out_tool);
                if (a.out_extrude !== e.out_extrude)
                    $error("out_extrude exp %0d got %0d", e.out_extrude, a.out_extrude);
                if (a.out_ev_code !== e.out_ev_code)
                    $error("out_ev_code exp %0d got %0d", e.out_ev_code,
                           a.out_ev_code);
                if (a.last_of_run !== e.last_of_run)
                    $error("last_of_run exp %0d got %0d", e.last_of_run, a.last_of_run);
            end
        endfunction
    endclass
endpackage

[tb/testbench.sv]
// Testbench top for the motion point sequencer with event hold.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mps_pkg::*;
    import mps_tb_pkg::*;

    localparam int PDEPTH = PointDepthDefault;
    localparam int EDEPTH = EventDepthDefault;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    mps_in_if  req_ch();
    mps_out_if res_ch();

    seq_scoreboard board = new(PDEPTH, EDEPTH);

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          recv_holdoff = 0;
    logic [31:0] stream_seq = '0;

    motion_point_sequencer_with_event_hold uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_ch.sink),
        .o_res(res_ch.source),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        res_ch.ready = 1'b0;
    end

    // Receiver: random stalls plus an optional long hold-off.
    always @(posedge i_clk) begin
        if (res_ch.valid && res_ch.ready) board.check_result(res_ch.payload);
        if (recv_holdoff > 0) begin
            recv_holdoff <= recv_holdoff - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Valid stays high after an accepted request until the next request or
    // an idle cycle replaces it.
    task automatic send_request(t_in r);
        if ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        board.note_request(r);
    endtask

    function automatic t_in random_fields(t_req kind);
        t_in r;
        r.req_type = kind;
        r.seq = $urandom;
        r.pos_x = $urandom;
        r.pos_y = $urandom;
        r.pos_z = $urandom;
        r.rot_a = $urandom;
        r.rot_b = $urandom;
        r.rot_c = $urandom;
        r.tool_id = 8'($urandom);
        r.extrude = $urandom;
        r.ev_code = 8'($urandom);
        r.ready_req = 1'($urandom);
        return r;
    endfunction

    task automatic push_point(logic [31:0] s);
        t_in r = random_fields(REQ_POINT);
        r.seq = s;
        send_request(r);
    endtask

    task automatic push_event(logic [31:0] s, logic [7:0] t);
        t_in r = random_fields(REQ_EVENT);
        r.seq = s;
        r.ev_code = t;
        send_request(r);
    endtask

    task automatic report_status(logic ok, logic [31:0] s, logic [7:0] t);
        t_in r = random_fields(REQ_STATUS);
        r.ready_req = ok;
        r.seq = s;
        r.ev_code = t;
        send_request(r);
    endtask

    task automatic tick();
        send_request(random_fields(REQ_TICK));
    endtask

    // Waits for all results and lets a tick in flight settle.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (board.expected.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_holdoff(logic [15:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.holdoff = v;
    endtask

    // A burst of well-formed traffic: in-order points, some gaps and stale
    // points, occasional events with matching or mismatching ready reports.
    task automatic traffic(int n);
        int k;
        logic [31:0] s;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            s = board.exp_seq;
            if (k < 40) begin
                push_point(stream_seq);
                stream_seq++;
            end else if (k < 45) begin
                push_point(s + $urandom_range(1, 5));
            end else if (k < 48) begin
                push_point(s - $urandom_range(1, 3));
            end else if (k < 52) begin
                push_event(s + $urandom_range(0, 2) - 1, 8'($urandom));
            end else if (k < 62) begin
                if (board.pend_valid && $urandom_range(3) != 0)
                    report_status(1'b1, board.pend[31:0], board.pend[39:32]);
                else
                    report_status($urandom_range(3) != 0, $urandom_range(3) == 0 ?
                                  $urandom : s, 8'($urandom));
            end else if (k < 64) begin
                send_request(random_fields(t_req'($urandom_range(2))));
            end else begin
                if (board.exp_seq > stream_seq || $urandom_range(15) == 0)
                    stream_seq = board.exp_seq;
                tick();
            end
        end
    endtask

    initial begin
        t_in r;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: initial wait, extreme fields, events, resync and throttle.
        tick();
        report_status(1'b1, 32'hFFFF_FFFF, 8'hFF);
        tick();
        r = '0;
        r.req_type = REQ_POINT;
        send_request(r);
        r = '1;
        r.req_type = REQ_POINT;
        r.seq = 32'd1;
        send_request(r);
        tick();
        tick();
        push_event(32'd2, 8'hA5);
        push_point(32'd2);
        tick();
        tick();
        report_status(1'b1, 32'd2, 8'h00);
        tick();
        report_status(1'b1, 32'd2, 8'hA5);
        tick();
        tick();
        push_point(32'd9);
        tick();
        push_point(32'd9);
        tick();
        write_holdoff(16'd0);
        push_point(32'd9);
        tick();
        push_point(32'd1);
        tick();
        write_holdoff(16'hFFFF);
        stream_seq = board.exp_seq;

        // Overfill the point queue with points ahead, flush it, then overfill
        // the event queue with due events.
        drain();
        for (int i = 0; i < PDEPTH + 2; i++)
            push_point(board.exp_seq + 32'(i) + 32'd1);
        report_status(1'b1, board.pend[31:0], board.pend[39:32]);
        tick();
        tick();
        for (int i = 0; i < EDEPTH + 2; i++) push_event(board.exp_seq, 8'(i));
        tick();
        drain();
        write_holdoff(HoldoffReset);
        stream_seq = board.exp_seq;

        send_idle_pct = 26;
        recv_idle_pct = 76;
        traffic(180);
        write_holdoff(16'd3);
        send_idle_pct = 76;
        recv_idle_pct = 26;
        traffic(180);
        write_holdoff(16'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        traffic(100);

        // Long receiver hold-off while requests keep coming.
        recv_holdoff = 300;
        traffic(100);
        drain();
        traffic(50);

        drain();
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule
